// ----- rtl/hid_rdp_pkg.sv -----
// Package: payload types, record kinds, sequencer states and usage tables.
`timescale 1ns / 1ps
package hid_rdp_pkg;

   typedef struct packed {
      logic [7:0] desc_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]         kind;
      logic [15:0]        bit_offset;
      logic [7:0]         bit_size;
      logic signed [31:0] logical_min;
      logic signed [31:0] logical_max;
      logic [4:0]         button_count;
      logic [7:0]         report_id;
      logic               layout_valid;
      logic               last_of_run;
   } rsp_type;

   localparam logic [3:0] KIND_HAT     = 4'd6;
   localparam logic [3:0] KIND_BUTTONS = 4'd7;
   localparam logic [3:0] KIND_RID     = 4'd8;
   localparam logic [3:0] KIND_END     = 4'd9;

   localparam logic [7:0]  PREFIX_LONG  = 8'hFE;
   localparam logic [31:0] PAGE_DESKTOP = 32'h01;
   localparam logic [31:0] PAGE_SIM     = 32'h02;
   localparam logic [31:0] PAGE_BUTTON  = 32'h09;

   localparam logic [1:0] TYPE_MAIN   = 2'd0;
   localparam logic [1:0] TYPE_GLOBAL = 2'd1;
   localparam logic [1:0] TYPE_LOCAL  = 2'd2;

   localparam logic [3:0] TAG_INPUT     = 4'h8;
   localparam logic [3:0] TAG_PAGE      = 4'h0;
   localparam logic [3:0] TAG_LMIN      = 4'h1;
   localparam logic [3:0] TAG_LMAX      = 4'h2;
   localparam logic [3:0] TAG_RSIZE     = 4'h7;
   localparam logic [3:0] TAG_RID       = 4'h8;
   localparam logic [3:0] TAG_RCOUNT    = 4'h9;
   localparam logic [3:0] TAG_USAGE     = 4'h0;
   localparam logic [3:0] TAG_USAGE_MIN = 4'h1;
   localparam logic [3:0] TAG_USAGE_MAX = 4'h2;

   typedef enum logic [1:0] {
      PH_PREFIX   = 2'd0,
      PH_DATA     = 2'd1,
      PH_LONGSIZE = 2'd2,
      PH_LONGSKIP = 2'd3
   } phase_type;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_BYTE  = 11'b00000000010,
      ST_RID   = 11'b00000000100,
      ST_DISP  = 11'b00000001000,
      ST_LREAD = 11'b00000010000,
      ST_LCHK  = 11'b00000100000,
      ST_RSCAN = 11'b00001000000,
      ST_RTAKE = 11'b00010000000,
      ST_CLR   = 11'b00100000000,
      ST_FIN   = 11'b01000000000,
      ST_FLUSH = 11'b10000000000
   } state_type;

   // Map a usage to a layout kind: bit 3 is the hit flag.
   function automatic logic [3:0] kind_lookup(input logic [31:0] page,
                                              input logic [31:0] usage);
      logic [3:0] r;
      r = 4'd0;
      if (page == PAGE_DESKTOP) begin
         case (usage)
            32'h30: r = 4'b1000;
            32'h31: r = 4'b1001;
            32'h32: r = 4'b1010;
            32'h35: r = 4'b1011;
            32'h33: r = 4'b1100;
            32'h34: r = 4'b1101;
            32'h39: r = 4'b1110;
            default: r = 4'd0;
         endcase
      end else if (page == PAGE_SIM) begin
         case (usage)
            32'hC5: r = 4'b1100;
            32'hC4: r = 4'b1101;
            default: r = 4'd0;
         endcase
      end
      return r;
   endfunction

   // Usage at table slot for range scans; the kind equals the slot number on the desktop page.
   function automatic logic [34:0] range_entry(input logic sim, input logic [2:0] slot);
      logic [34:0] r;
      r = '0;
      if (sim) begin
         r = (slot == 3'd0) ? {3'd4, 32'hC5} : {3'd5, 32'hC4};
      end else begin
         case (slot)
            3'd0: r = {3'd0, 32'h30};
            3'd1: r = {3'd1, 32'h31};
            3'd2: r = {3'd2, 32'h32};
            3'd3: r = {3'd3, 32'h35};
            3'd4: r = {3'd4, 32'h33};
            3'd5: r = {3'd5, 32'h34};
            default: r = {3'd6, 32'h39};
         endcase
      end
      return r;
   endfunction

endpackage

// ----- rtl/hid_report_descriptor_parser.sv -----
// HID report descriptor parser: item assembly, global/local state and layout records.
//
// Descriptor bytes enter one beat at a time; the parser is not ready while a byte is being
// worked. An ordinary byte passes through accept, parse, end check and record flush states,
// and a byte that completes a main item also passes a clear state for the local usages. A
// non-constant Input item with nonzero size and count adds a sequencer walk: a report id
// state and a dispatch state, then for a usage list a read and a check state per listed
// usage walked plus a closing read, or for a usage range one full table scan (seven slots,
// two on the simulation page) per found entry plus a take state each, and a final scan that
// finds nothing. A shared 16-bit multiply-add forms each axis field offset. Records leave
// through a staging register and an output register, so a stalled consumer stalls the walk.
`timescale 1ns / 1ps
module hid_report_descriptor_parser #(
   parameter int MAX_USAGES  = 16,
   parameter int MAX_BUTTONS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hid_rdp_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hid_rdp_pkg::rsp_type rsp_data
);

   localparam int FW   = $clog2(MAX_USAGES + 1);
   localparam int IDXW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;

   hid_rdp_pkg::state_type state_ff, state_in;
   hid_rdp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [7:0]  prefix_ff, prefix_in;
   logic [31:0] data_ff, data_in;
   logic [8:0]  left_ff, left_in;
   logic        stopped_ff, stopped_in;
   logic [31:0] page_ff, page_in;
   logic [31:0] fsize_ff, fsize_in;
   logic [31:0] fcount_ff, fcount_in;
   logic [31:0] min_ff, min_in;
   logic [31:0] max_ff, max_in;
   logic [7:0]  cur_id_ff, cur_id_in;
   logic [31:0] cursor_ff, cursor_in;
   logic [31:0] start_ff, start_in;
   logic        locked_ff, locked_in;
   logic [7:0]  lock_id_ff, lock_id_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0] base_ff, base_in;
   logic        range_ff, range_in;
   logic [7:0]  taken_ff, taken_in;
   logic [FW-1:0] f_ff, f_in;
   logic [2:0]  t_ff, t_in;
   logic        best_v_ff, best_v_in;
   logic [31:0] best_f_ff, best_f_in;
   logic [2:0]  best_k_ff, best_k_in;
   logic [31:0] rd_ff;
   hid_rdp_pkg::rsp_type pend_ff, pend_in, out_ff, out_in;
   logic        pend_v_ff, pend_v_in, out_v_ff, out_v_in;

   logic [31:0] usage_mem [MAX_USAGES];
   logic        mem_we;

   // Working signals.
   logic        out_free, slot_ok, prod;
   hid_rdp_pkg::rsp_type prod_rec;
   logic        run_go;
   logic [7:0]  run_prefix;
   logic [31:0] run_data;
   logic [2:0]  run_len, cur_len;
   logic [1:0]  pos;
   logic [31:0] cursor_step;
   logic [15:0] mul_f, offset16;
   logic [3:0]  lk;
   logic [34:0] rentry;
   logic [31:0] rf;
   logic        rcand, rbetter;
   logic [4:0]  btn_cnt;

   assign req_ready = (state_ff == hid_rdp_pkg::ST_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_v_ff || rsp_ready;
   assign slot_ok   = !pend_v_ff || out_free;

   assign cursor_step = 32'(fsize_ff * fcount_ff);
   assign mul_f       = (state_ff == hid_rdp_pkg::ST_LCHK) ? 16'(f_ff) : best_f_ff[15:0];
   assign offset16    = 16'(start_ff[15:0] + 16'(mul_f * fsize_ff[15:0]));
   assign lk          = hid_rdp_pkg::kind_lookup(page_ff, rd_ff);
   assign rentry      = hid_rdp_pkg::range_entry(page_ff != hid_rdp_pkg::PAGE_DESKTOP, t_ff);
   assign rf          = rentry[31:0] - base_ff;
   assign rcand       = (rf < fcount_ff) && !taken_ff[rentry[34:32]];
   assign rbetter     = rcand && (!best_v_ff || rf < best_f_ff);
   assign btn_cnt     = (fcount_ff > 32'(MAX_BUTTONS)) ? 5'(MAX_BUTTONS) : fcount_ff[4:0];
   assign cur_len     = (prefix_ff[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix_ff[1:0]};

   // Sequencer and parse state.
   always_comb begin
      state_in = state_ff;     phase_in = phase_ff;   byte_in = byte_ff;
      last_in = last_ff;       prefix_in = prefix_ff; data_in = data_ff;
      left_in = left_ff;       stopped_in = stopped_ff; page_in = page_ff;
      fsize_in = fsize_ff;     fcount_in = fcount_ff; min_in = min_ff;
      max_in = max_ff;         cur_id_in = cur_id_ff; cursor_in = cursor_ff;
      start_in = start_ff;     locked_in = locked_ff; lock_id_in = lock_id_ff;
      fill_in = fill_ff;       base_in = base_ff;     range_in = range_ff;
      taken_in = taken_ff;     f_in = f_ff;           t_in = t_ff;
      best_v_in = best_v_ff;   best_f_in = best_f_ff; best_k_in = best_k_ff;
      prod = 1'b0;             prod_rec = '0;         mem_we = 1'b0;
      run_go = 1'b0;           run_prefix = prefix_ff; run_data = data_ff;
      run_len = cur_len;       pos = 2'd0;
      out_in = out_ff;         out_v_in = out_v_ff && !rsp_ready;
      pend_in = pend_ff;       pend_v_in = pend_v_ff;

      unique case (state_ff)
         hid_rdp_pkg::ST_IDLE: begin
            if (req_valid) begin
               byte_in  = req_data.desc_byte;
               last_in  = req_data.last_byte;
               state_in = hid_rdp_pkg::ST_BYTE;
            end
         end
         hid_rdp_pkg::ST_BYTE: begin
            state_in = hid_rdp_pkg::ST_FIN;
            if (!stopped_ff) begin
               case (phase_ff)
                  hid_rdp_pkg::PH_PREFIX: begin
                     prefix_in = byte_ff;
                     data_in   = '0;
                     run_prefix = byte_ff;
                     run_data  = '0;
                     run_len   = (byte_ff[1:0] == 2'd3) ? 3'd4 : {1'b0, byte_ff[1:0]};
                     if (byte_ff == hid_rdp_pkg::PREFIX_LONG) begin
                        if (last_ff) stopped_in = 1'b1;
                        else phase_in = hid_rdp_pkg::PH_LONGSIZE;
                     end else if (run_len == 3'd0) begin
                        run_go = 1'b1;
                     end else if (last_ff) begin
                        stopped_in = 1'b1;
                     end else begin
                        left_in  = {6'd0, run_len};
                        phase_in = hid_rdp_pkg::PH_DATA;
                     end
                  end
                  hid_rdp_pkg::PH_DATA: begin
                     pos      = 2'(cur_len - left_ff[2:0]);
                     data_in  = data_ff | ({24'd0, byte_ff} << {pos, 3'd0});
                     run_data = data_in;
                     left_in  = left_ff - 9'd1;
                     if (left_in == 9'd0) begin
                        phase_in = hid_rdp_pkg::PH_PREFIX;
                        run_go   = 1'b1;
                     end else if (last_ff) begin
                        stopped_in = 1'b1;
                     end
                  end
                  hid_rdp_pkg::PH_LONGSIZE: begin
                     left_in  = {1'b0, byte_ff} + 9'd1;
                     phase_in = hid_rdp_pkg::PH_LONGSKIP;
                  end
                  default: begin
                     left_in = left_ff - 9'd1;
                     if (left_in == 9'd0) phase_in = hid_rdp_pkg::PH_PREFIX;
                  end
               endcase
            end
            // Execute a completed short item.
            if (run_go) begin
               case (run_prefix[3:2])
                  hid_rdp_pkg::TYPE_MAIN: begin
                     state_in = hid_rdp_pkg::ST_CLR;
                     if (run_prefix[7:4] == hid_rdp_pkg::TAG_INPUT) begin
                        start_in  = cursor_ff;
                        cursor_in = cursor_ff + cursor_step;
                        if (!run_data[0] && fsize_ff != '0 && fcount_ff != '0)
                           state_in = hid_rdp_pkg::ST_RID;
                     end
                  end
                  hid_rdp_pkg::TYPE_GLOBAL: begin
                     case (run_prefix[7:4])
                        hid_rdp_pkg::TAG_PAGE:   page_in = run_data;
                        hid_rdp_pkg::TAG_LMIN, hid_rdp_pkg::TAG_LMAX: begin
                           logic [31:0] sx;
                           if (run_len == 3'd1) sx = {{24{run_data[7]}}, run_data[7:0]};
                           else if (run_len == 3'd2) sx = {{16{run_data[15]}}, run_data[15:0]};
                           else sx = run_data;
                           if (run_prefix[7:4] == hid_rdp_pkg::TAG_LMIN) min_in = sx;
                           else max_in = sx;
                        end
                        hid_rdp_pkg::TAG_RSIZE:  fsize_in = run_data;
                        hid_rdp_pkg::TAG_RID: begin
                           cur_id_in = run_data[7:0];
                           cursor_in = '0;
                        end
                        hid_rdp_pkg::TAG_RCOUNT: fcount_in = run_data;
                        default: ;
                     endcase
                  end
                  hid_rdp_pkg::TYPE_LOCAL: begin
                     if (run_prefix[7:4] == hid_rdp_pkg::TAG_USAGE) begin
                        if (32'(fill_ff) < 32'(MAX_USAGES)) begin
                           mem_we  = 1'b1;
                           fill_in = fill_ff + FW'(1);
                        end
                     end else if (run_prefix[7:4] == hid_rdp_pkg::TAG_USAGE_MIN) begin
                        base_in  = run_data;
                        range_in = 1'b1;
                     end else if (run_prefix[7:4] == hid_rdp_pkg::TAG_USAGE_MAX) begin
                        range_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         hid_rdp_pkg::ST_RID: begin
            if (locked_ff) begin
               state_in = hid_rdp_pkg::ST_DISP;
            end else if (slot_ok) begin
               prod = 1'b1;
               prod_rec.kind = hid_rdp_pkg::KIND_RID;
               prod_rec.report_id = cur_id_ff;
               locked_in  = 1'b1;
               lock_id_in = cur_id_ff;
               state_in   = hid_rdp_pkg::ST_DISP;
            end
         end
         hid_rdp_pkg::ST_DISP: begin
            state_in = hid_rdp_pkg::ST_CLR;
            if (cur_id_ff == lock_id_ff) begin
               if (page_ff == hid_rdp_pkg::PAGE_BUTTON) begin
                  if (!taken_ff[7]) begin
                     if (slot_ok) begin
                        prod = 1'b1;
                        prod_rec.kind = hid_rdp_pkg::KIND_BUTTONS;
                        prod_rec.bit_offset = start_ff[15:0];
                        prod_rec.bit_size = 8'd1;
                        prod_rec.button_count = btn_cnt;
                        taken_in[7] = 1'b1;
                     end else begin
                        state_in = hid_rdp_pkg::ST_DISP;
                     end
                  end
               end else if (page_ff == hid_rdp_pkg::PAGE_DESKTOP ||
                            page_ff == hid_rdp_pkg::PAGE_SIM) begin
                  f_in = '0;
                  t_in = '0;
                  best_v_in = 1'b0;
                  state_in = range_ff ? hid_rdp_pkg::ST_RSCAN : hid_rdp_pkg::ST_LREAD;
               end
            end
         end
         hid_rdp_pkg::ST_LREAD: begin
            if (32'(f_ff) < fcount_ff && f_ff < fill_ff) state_in = hid_rdp_pkg::ST_LCHK;
            else state_in = hid_rdp_pkg::ST_CLR;
         end
         hid_rdp_pkg::ST_LCHK: begin
            if (lk[3] && !taken_ff[lk[2:0]]) begin
               if (slot_ok) begin
                  prod = 1'b1;
                  prod_rec.kind = {1'b0, lk[2:0]};
                  prod_rec.bit_offset = offset16;
                  prod_rec.bit_size = fsize_ff[7:0];
                  prod_rec.logical_min = min_ff;
                  prod_rec.logical_max = max_ff;
                  taken_in[lk[2:0]] = 1'b1;
                  f_in = f_ff + FW'(1);
                  state_in = hid_rdp_pkg::ST_LREAD;
               end
            end else begin
               f_in = f_ff + FW'(1);
               state_in = hid_rdp_pkg::ST_LREAD;
            end
         end
         hid_rdp_pkg::ST_RSCAN: begin
            if (rbetter) begin
               best_v_in = 1'b1;
               best_f_in = rf;
               best_k_in = rentry[34:32];
            end
            if ((page_ff == hid_rdp_pkg::PAGE_DESKTOP && t_ff == 3'd6) ||
                (page_ff != hid_rdp_pkg::PAGE_DESKTOP && t_ff == 3'd1)) begin
               t_in = '0;
               state_in = best_v_in ? hid_rdp_pkg::ST_RTAKE : hid_rdp_pkg::ST_CLR;
            end else begin
               t_in = t_ff + 3'd1;
            end
         end
         hid_rdp_pkg::ST_RTAKE: begin
            if (slot_ok) begin
               prod = 1'b1;
               prod_rec.kind = {1'b0, best_k_ff};
               prod_rec.bit_offset = offset16;
               prod_rec.bit_size = fsize_ff[7:0];
               prod_rec.logical_min = min_ff;
               prod_rec.logical_max = max_ff;
               taken_in[best_k_ff] = 1'b1;
               best_v_in = 1'b0;
               state_in = hid_rdp_pkg::ST_RSCAN;
            end
         end
         hid_rdp_pkg::ST_CLR: begin
            fill_in  = '0;
            range_in = 1'b0;
            base_in  = '0;
            state_in = hid_rdp_pkg::ST_FIN;
         end
         hid_rdp_pkg::ST_FIN: begin
            if (!last_ff) begin
               state_in = hid_rdp_pkg::ST_FLUSH;
            end else if (slot_ok) begin
               prod = 1'b1;
               prod_rec.kind = hid_rdp_pkg::KIND_END;
               prod_rec.layout_valid = taken_ff[0] | taken_ff[1] | taken_ff[6] | taken_ff[7];
               // Return the parse state to its reset value.
               phase_in = hid_rdp_pkg::PH_PREFIX; prefix_in = '0; data_in = '0;
               left_in = '0;  stopped_in = 1'b0; page_in = '0;  fsize_in = '0;
               fcount_in = '0; min_in = '0;  max_in = '0;  cur_id_in = '0;
               cursor_in = '0; locked_in = 1'b0; lock_id_in = '0; fill_in = '0;
               base_in = '0;  range_in = 1'b0; taken_in = '0;
               state_in = hid_rdp_pkg::ST_FLUSH;
            end
         end
         hid_rdp_pkg::ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = hid_rdp_pkg::ST_IDLE;
            end else if (out_free) begin
               out_in = pend_ff;
               out_in.last_of_run = 1'b1;
               out_v_in  = 1'b1;
               pend_v_in = 1'b0;
               state_in  = hid_rdp_pkg::ST_IDLE;
            end
         end
         default: state_in = hid_rdp_pkg::ST_IDLE;
      endcase

      // Stage a new record; push the older one to the output register.
      if (prod) begin
         if (pend_v_ff) begin
            out_in   = pend_ff;
            out_v_in = 1'b1;
         end
         pend_in   = prod_rec;
         pend_v_in = 1'b1;
      end
   end

   // Usage list storage and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) usage_mem[fill_ff[IDXW-1:0]] <= run_data;
      if (state_ff == hid_rdp_pkg::ST_LREAD) rd_ff <= usage_mem[f_ff[IDXW-1:0]];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hid_rdp_pkg::ST_IDLE;  phase_ff <= hid_rdp_pkg::PH_PREFIX;
         left_ff <= '0;      stopped_ff <= 1'b0;  page_ff <= '0;
         fsize_ff <= '0;     fcount_ff <= '0;     min_ff <= '0;
         max_ff <= '0;       cur_id_ff <= '0;     cursor_ff <= '0;
         locked_ff <= 1'b0;  lock_id_ff <= '0;    fill_ff <= '0;
         base_ff <= '0;      range_ff <= 1'b0;    taken_ff <= '0;
         prefix_ff <= '0;    data_ff <= '0;       best_v_ff <= 1'b0;
         pend_v_ff <= 1'b0;  out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;    phase_ff <= phase_in;
         left_ff <= left_in;      stopped_ff <= stopped_in; page_ff <= page_in;
         fsize_ff <= fsize_in;    fcount_ff <= fcount_in;   min_ff <= min_in;
         max_ff <= max_in;        cur_id_ff <= cur_id_in;   cursor_ff <= cursor_in;
         locked_ff <= locked_in;  lock_id_ff <= lock_id_in; fill_ff <= fill_in;
         base_ff <= base_in;      range_ff <= range_in;     taken_ff <= taken_in;
         prefix_ff <= prefix_in;  data_ff <= data_in;       best_v_ff <= best_v_in;
         pend_v_ff <= pend_v_in;  out_v_ff <= out_v_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;    last_ff <= last_in;   start_ff <= start_in;
      f_ff <= f_in;          t_ff <= t_in;         best_f_ff <= best_f_in;
      best_k_ff <= best_k_in; pend_ff <= pend_in;  out_ff <= out_in;
   end

   // The staging register is empty whenever the parser waits for a byte.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hid_rdp_pkg::ST_IDLE) |-> !pend_v_ff)
      else $error("staged record left behind at idle");

   // An accepted beat is parsed in the next cycle.
   a_accept_parse: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == hid_rdp_pkg::ST_BYTE))
      else $error("accepted beat not parsed");

   // The usage list never overfills.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_USAGES))
      else $error("usage list overfilled");

   // A stalled output beat holds its payload.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("output beat changed while stalled");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the HID report descriptor layout parser.
`timescale 1ns / 1ps
module tb;

   localparam int USAGE_DEPTH = 16;
   localparam int BUTTON_CAP  = 16;
   localparam logic [1:0] TYPE_RSVD = 2'd3;
   localparam logic [3:0] TAG_COLLECTION = 4'hA;
   localparam logic [3:0] TAG_END_COLL   = 4'hC;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   hid_rdp_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   hid_rdp_pkg::rsp_type rsp_data;

   int send_idle = 18;
   int recv_idle = 80;
   int err_count = 0;

   hid_rdp_pkg::rsp_type expected_records[$];
   hid_rdp_pkg::rsp_type step_records[$];
   logic [7:0] desc_q[$];

   hid_report_descriptor_parser uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------- parser model state ----------------
   logic [31:0] desk_usage [7] = '{32'h30, 32'h31, 32'h32, 32'h35, 32'h33, 32'h34, 32'h39};
   logic [31:0] sim_usage  [2] = '{32'hC5, 32'hC4};

   hid_rdp_pkg::phase_type m_phase;
   logic [7:0]  m_prefix;
   logic [31:0] m_data, m_left;
   bit          m_stopped;
   logic [31:0] m_page, m_size, m_count, m_min, m_max, m_cursor, m_base;
   logic [7:0]  m_cur_id, m_lock_id, m_taken;
   bit          m_locked, m_ranged;
   logic [31:0] m_usages [USAGE_DEPTH];
   int          m_fill;

   task model_reset;
      m_phase = hid_rdp_pkg::PH_PREFIX; m_prefix = '0; m_data = '0; m_left = '0;
      m_stopped = 0;
      m_page = '0; m_size = '0; m_count = '0; m_min = '0; m_max = '0; m_cursor = '0;
      m_base = '0; m_cur_id = '0; m_lock_id = '0; m_taken = '0; m_locked = 0;
      m_ranged = 0; m_fill = 0;
   endtask

   task add_record(input logic [3:0] k, input logic [31:0] off, input logic [31:0] sz,
                   input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] bc,
                   input logic [7:0] rid, input logic v);
      hid_rdp_pkg::rsp_type r;
      r.kind = k; r.bit_offset = off[15:0]; r.bit_size = sz[7:0];
      r.logical_min = lo; r.logical_max = hi; r.button_count = bc[4:0];
      r.report_id = rid; r.layout_valid = v; r.last_of_run = 1'b0;
      step_records.push_back(r);
   endtask

   function automatic int usage_kind(input logic [31:0] page, input logic [31:0] u);
      int k;
      if (page == hid_rdp_pkg::PAGE_DESKTOP) begin
         for (k = 0; k < 7; k++) if (desk_usage[k] == u) return k;
      end else if (page == hid_rdp_pkg::PAGE_SIM) begin
         for (k = 0; k < 2; k++) if (sim_usage[k] == u) return 4 + k;
      end
      return -1;
   endfunction

   task take_entry(input int k, input logic [31:0] start, input logic [31:0] f);
      if (!m_taken[k]) begin
         m_taken[k] = 1'b1;
         add_record(k[3:0], start + f * m_size, m_size, m_min, m_max, 0, 8'd0, 1'b0);
      end
   endtask

   // Declare axis fields in field order, from a range or from the usage list.
   task walk_axes(input logic [31:0] start);
      logic [31:0] fs [7];
      int ks [7];
      bit used [7];
      int nc, best, k, j, nt, kk;
      logic [31:0] u, f, lim;
      if (m_ranged) begin
         nc = 0;
         nt = (m_page == hid_rdp_pkg::PAGE_DESKTOP) ? 7 : 2;
         for (k = 0; k < nt; k++) begin
            u = (m_page == hid_rdp_pkg::PAGE_DESKTOP) ? desk_usage[k] : sim_usage[k];
            kk = (m_page == hid_rdp_pkg::PAGE_DESKTOP) ? k : 4 + k;
            f = u - m_base;
            if (f < m_count && !m_taken[kk]) begin
               fs[nc] = f; ks[nc] = kk; used[nc] = 0; nc++;
            end
         end
         for (j = 0; j < nc; j++) begin
            best = nc;
            for (k = 0; k < nc; k++)
               if (!used[k] && (best == nc || fs[k] < fs[best])) best = k;
            used[best] = 1;
            take_entry(ks[best], start, fs[best]);
         end
      end else begin
         lim = (m_count < m_fill) ? m_count : m_fill;
         for (f = 0; f < lim && f < USAGE_DEPTH; f++) begin
            kk = usage_kind(m_page, m_usages[f]);
            if (kk >= 0) take_entry(kk, start, f);
         end
      end
   endtask

   task input_item;
      logic [31:0] start, bc;
      start = m_cursor;
      m_cursor = m_cursor + m_size * m_count;
      if (!(m_data[0] || m_size == 0 || m_count == 0)) begin
         if (!m_locked) begin
            m_locked = 1; m_lock_id = m_cur_id;
            add_record(hid_rdp_pkg::KIND_RID, 0, 0, 0, 0, 0, m_cur_id, 1'b0);
         end
         if (m_cur_id == m_lock_id) begin
            if (m_page == hid_rdp_pkg::PAGE_BUTTON) begin
               if (!m_taken[7]) begin
                  bc = (m_count > BUTTON_CAP) ? BUTTON_CAP : m_count;
                  m_taken[7] = 1'b1;
                  add_record(hid_rdp_pkg::KIND_BUTTONS, start, 1, 0, 0, bc, 8'd0, 1'b0);
               end
            end else if (m_page == hid_rdp_pkg::PAGE_DESKTOP ||
                         m_page == hid_rdp_pkg::PAGE_SIM) begin
               walk_axes(start);
            end
         end
      end
   endtask

   function automatic logic [31:0] sign_extend(input logic [31:0] v, input int len);
      if (len == 1) return {{24{v[7]}}, v[7:0]};
      if (len == 2) return {{16{v[15]}}, v[15:0]};
      return v;
   endfunction

   task run_item(input int len);
      logic [1:0] typ;
      logic [3:0] tag;
      typ = m_prefix[3:2];
      tag = m_prefix[7:4];
      if (typ == hid_rdp_pkg::TYPE_MAIN) begin
         if (tag == hid_rdp_pkg::TAG_INPUT) input_item();
         m_fill = 0; m_ranged = 0; m_base = '0;
      end else if (typ == hid_rdp_pkg::TYPE_GLOBAL) begin
         case (tag)
            hid_rdp_pkg::TAG_PAGE:   m_page = m_data;
            hid_rdp_pkg::TAG_LMIN:   m_min = sign_extend(m_data, len);
            hid_rdp_pkg::TAG_LMAX:   m_max = sign_extend(m_data, len);
            hid_rdp_pkg::TAG_RSIZE:  m_size = m_data;
            hid_rdp_pkg::TAG_RID:    begin m_cur_id = m_data[7:0]; m_cursor = '0; end
            hid_rdp_pkg::TAG_RCOUNT: m_count = m_data;
            default: ;
         endcase
      end else if (typ == hid_rdp_pkg::TYPE_LOCAL) begin
         if (tag == hid_rdp_pkg::TAG_USAGE) begin
            if (m_fill < USAGE_DEPTH) begin
               m_usages[m_fill] = m_data; m_fill++;
            end
         end else if (tag == hid_rdp_pkg::TAG_USAGE_MIN) begin
            m_base = m_data; m_ranged = 1;
         end else if (tag == hid_rdp_pkg::TAG_USAGE_MAX) begin
            m_ranged = 1;
         end
      end
   endtask

   function automatic int item_len(input logic [7:0] p);
      return (p[1:0] == 2'd3) ? 4 : p[1:0];
   endfunction

   // Advance the model by one accepted beat and queue the records it causes.
   task predict_byte(input logic [7:0] b, input logic last);
      int pos;
      hid_rdp_pkg::rsp_type r;
      if (!m_stopped) begin
         case (m_phase)
            hid_rdp_pkg::PH_PREFIX: begin
               m_prefix = b; m_data = '0;
               if (b == hid_rdp_pkg::PREFIX_LONG) begin
                  if (last) m_stopped = 1; else m_phase = hid_rdp_pkg::PH_LONGSIZE;
               end else if (item_len(b) == 0) begin
                  run_item(0);
               end else if (last) begin
                  m_stopped = 1;
               end else begin
                  m_left = item_len(b); m_phase = hid_rdp_pkg::PH_DATA;
               end
            end
            hid_rdp_pkg::PH_DATA: begin
               pos = (item_len(m_prefix) - m_left) & 3;
               m_data = m_data | ({24'd0, b} << (8 * pos));
               m_left = m_left - 1;
               if (m_left == 0) begin
                  m_phase = hid_rdp_pkg::PH_PREFIX;
                  run_item(item_len(m_prefix));
               end else if (last) begin
                  m_stopped = 1;
               end
            end
            hid_rdp_pkg::PH_LONGSIZE: begin
               m_left = b + 1; m_phase = hid_rdp_pkg::PH_LONGSKIP;
            end
            default: begin
               m_left = m_left - 1;
               if (m_left == 0) m_phase = hid_rdp_pkg::PH_PREFIX;
            end
         endcase
      end
      if (last) begin
         add_record(hid_rdp_pkg::KIND_END, 0, 0, 0, 0, 0, 8'd0,
                    m_taken[0] | m_taken[1] | m_taken[6] | m_taken[7]);
         model_reset();
      end
      if (step_records.size() > 0) begin
         r = step_records.pop_back();
         r.last_of_run = 1'b1;
         step_records.push_back(r);
      end
      while (step_records.size() > 0) expected_records.push_back(step_records.pop_front());
   endtask

   // ---------------- driving ----------------
   task send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{desc_byte: b, last_byte: last};
      do @(posedge clock); while (!req_ready);
      predict_byte(b, last);
   endtask

   task send_desc;
      int i;
      for (i = 0; i < desc_q.size(); i++) send_byte(desc_q[i], i == desc_q.size() - 1);
      desc_q.delete();
   endtask

   task put_item(input logic [1:0] typ, input logic [3:0] tag, input int len,
                 input logic [31:0] d);
      int i;
      desc_q.push_back({tag, typ, (len == 4) ? 2'd3 : len[1:0]});
      for (i = 0; i < len; i++) desc_q.push_back(d[8*i +: 8]);
   endtask

   function automatic int rand_len();
      int c;
      c = $urandom_range(3);
      return (c == 3) ? 4 : c;
   endfunction

   // ---------------- checking ----------------
   task report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      hid_rdp_pkg::rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            report("unexpected record kind", rsp_data.kind, 0);
         end else begin
            w = expected_records.pop_front();
            if (rsp_data.kind !== w.kind) report("kind", rsp_data.kind, w.kind);
            if (rsp_data.bit_offset !== w.bit_offset)
               report("bit_offset", rsp_data.bit_offset, w.bit_offset);
            if (rsp_data.bit_size !== w.bit_size)
               report("bit_size", rsp_data.bit_size, w.bit_size);
            if (rsp_data.logical_min !== w.logical_min)
               report("logical_min", rsp_data.logical_min, w.logical_min);
            if (rsp_data.logical_max !== w.logical_max)
               report("logical_max", rsp_data.logical_max, w.logical_max);
            if (rsp_data.button_count !== w.button_count)
               report("button_count", rsp_data.button_count, w.button_count);
            if (rsp_data.report_id !== w.report_id)
               report("report_id", rsp_data.report_id, w.report_id);
            if (rsp_data.layout_valid !== w.layout_valid)
               report("layout_valid", rsp_data.layout_valid, w.layout_valid);
            if (rsp_data.last_of_run !== w.last_of_run)
               report("last_of_run", rsp_data.last_of_run, w.last_of_run);
         end
      end
   end

   // ---------------- tests ----------------
   // Two signed 8-bit axes on the desktop page.
   task test_gamepad_axes;
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_PAGE, 1, hid_rdp_pkg::PAGE_DESKTOP);
      put_item(hid_rdp_pkg::TYPE_LOCAL, hid_rdp_pkg::TAG_USAGE, 1, 32'h30);
      put_item(hid_rdp_pkg::TYPE_LOCAL, hid_rdp_pkg::TAG_USAGE, 1, 32'h31);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_LMIN, 1, 32'h81);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_LMAX, 1, 32'h7F);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RSIZE, 1, 8);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RCOUNT, 1, 2);
      put_item(hid_rdp_pkg::TYPE_MAIN, hid_rdp_pkg::TAG_INPUT, 1, 32'h02);
      send_desc();
   endtask

   // Long item skip, then a truncated item and a lone long prefix on the last beat.
   task test_long_and_truncated;
      desc_q.push_back(hid_rdp_pkg::PREFIX_LONG);
      desc_q.push_back(8'h00);
      desc_q.push_back(8'hFF);
      desc_q.push_back(8'h00);
      desc_q.push_back(8'h26);
      send_desc();
      desc_q.push_back(hid_rdp_pkg::PREFIX_LONG);
      send_desc();
   endtask

   // Capped button field, then a usage range with a 16-bit logical maximum.
   task test_buttons_and_range;
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_PAGE, 1, hid_rdp_pkg::PAGE_BUTTON);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RSIZE, 1, 1);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RCOUNT, 1, 20);
      put_item(hid_rdp_pkg::TYPE_MAIN, hid_rdp_pkg::TAG_INPUT, 1, 32'h02);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_PAGE, 1, hid_rdp_pkg::PAGE_DESKTOP);
      put_item(hid_rdp_pkg::TYPE_LOCAL, hid_rdp_pkg::TAG_USAGE_MIN, 1, 32'h30);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_LMAX, 2, 32'hFFFF);
      put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RCOUNT, 1, 10);
      put_item(hid_rdp_pkg::TYPE_MAIN, hid_rdp_pkg::TAG_INPUT, 1, 32'h00);
      send_desc();
   endtask

   // Build one descriptor: mostly plausible layouts with random content, some noise.
   task build_random_desc;
      int nb, i, j, n, c;
      logic [31:0] page, v;
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(1, 30);
         for (i = 0; i < n; i++) desc_q.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(2) == 0)
            put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RID, 1, $urandom_range(3));
         nb = $urandom_range(1, 5);
         for (i = 0; i < nb; i++) begin
            c = $urandom_range(9);
            page = (c < 4) ? hid_rdp_pkg::PAGE_DESKTOP : (c < 6) ? hid_rdp_pkg::PAGE_SIM
                   : (c < 8) ? hid_rdp_pkg::PAGE_BUTTON : $urandom;
            put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_PAGE,
                     (page < 256) ? 1 : 4, page);
            if ($urandom_range(1))
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_LMIN, rand_len(), $urandom);
            if ($urandom_range(1))
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_LMAX, rand_len(), $urandom);
            c = $urandom_range(9);
            if (c == 0)
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RSIZE, 4, $urandom);
            else if (c == 1)
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RSIZE, 1,
                        $urandom_range(255));
            else
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RSIZE, 1,
                        $urandom_range(1, 16));
            c = $urandom_range(19);
            if (c == 0)
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RCOUNT, 4, $urandom);
            else if (c < 4)
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RCOUNT, 1,
                        $urandom_range(9, 40));
            else
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RCOUNT, 1,
                        $urandom_range(0, 8));
            if ($urandom_range(3) == 0) begin
               v = ((page == hid_rdp_pkg::PAGE_SIM) ? 32'hC0 : 32'h2D) + $urandom_range(0, 7);
               put_item(hid_rdp_pkg::TYPE_LOCAL, hid_rdp_pkg::TAG_USAGE_MIN, 1, v);
               if ($urandom_range(1))
                  put_item(hid_rdp_pkg::TYPE_LOCAL, hid_rdp_pkg::TAG_USAGE_MAX, 1, v + 8);
            end else begin
               n = $urandom_range(0, 18);
               for (j = 0; j < n; j++) begin
                  c = $urandom_range(3);
                  v = (c == 0) ? $urandom_range(255) : (c == 1) ? sim_usage[$urandom_range(1)]
                      : desk_usage[$urandom_range(6)];
                  put_item(hid_rdp_pkg::TYPE_LOCAL, hid_rdp_pkg::TAG_USAGE,
                           ($urandom_range(4) == 0) ? 2 : 1, v);
               end
            end
            // Sprinkle ignored and skipped items.
            c = $urandom_range(11);
            if (c == 0) begin
               desc_q.push_back(hid_rdp_pkg::PREFIX_LONG);
               n = $urandom_range(0, 3);
               desc_q.push_back(8'(n));
               for (j = 0; j <= n; j++) desc_q.push_back(8'($urandom_range(255)));
            end else if (c == 1) begin
               put_item(TYPE_RSVD, 4'($urandom_range(15)), rand_len(), $urandom);
            end else if (c == 2) begin
               put_item(hid_rdp_pkg::TYPE_MAIN, TAG_COLLECTION, 1, 1);
            end else if (c == 3) begin
               put_item(hid_rdp_pkg::TYPE_MAIN, TAG_END_COLL, 0, 0);
            end else if (c == 4) begin
               put_item(hid_rdp_pkg::TYPE_GLOBAL, hid_rdp_pkg::TAG_RID, 1, $urandom_range(3));
            end
            v = ($urandom_range(3) == 0) ? $urandom : 2 * $urandom_range(127);
            put_item(hid_rdp_pkg::TYPE_MAIN, hid_rdp_pkg::TAG_INPUT, rand_len(), v);
         end
         c = $urandom_range(7);
         if (c == 0) desc_q.push_back({4'($urandom_range(15)), 2'd1, 2'd2});
         else if (c == 1) desc_q.push_back(hid_rdp_pkg::PREFIX_LONG);
      end
   endtask

   task test_random_descriptors(input int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         build_random_desc();
         sent += desc_q.size();
         send_desc();
      end
   endtask

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      model_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 18; recv_idle = 80;
      test_gamepad_axes();
      test_long_and_truncated();
      test_buttons_and_range();
      test_random_descriptors(40);
      send_idle = 80; recv_idle = 18;
      test_random_descriptors(40);
      send_idle = 0; recv_idle = 0;
      test_random_descriptors(40);
      @(posedge clock);
      req_valid <= 1'b0;
      while (expected_records.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (err_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
